@@ design/rlev_pkg.sv @@
// Package for the RNG LES effective viscosity block.
// Holds item structs, register map, sequencer states and reset values; no dependencies.
package rlev_pkg;

	localparam int VALUE_WIDTH_DEF   = 64;
	localparam int FRACTION_BITS_DEF = 40;
	localparam int ADDR_WIDTH        = 4;

	localparam logic [31:0] TOL_RESET = 32'd110;
	localparam logic [15:0] MC_RESET  = 16'd100;
	localparam logic [23:0] UM_RESET  = 24'd10000000;

	typedef enum logic [1:0] {
		REG_TOL = 2'd0,
		REG_MC  = 2'd1,
		REG_UM  = 2'd2,
		REG_NONE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [63:0] laminar_viscosity;
		logic [63:0] subgrid_viscosity;
	} in_item_t;

	typedef struct packed {
		logic [63:0] effective_viscosity;
		logic        fell_back;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_L2,
		ST_L3,
		ST_CL3,
		ST_UB,
		ST_X2,
		ST_X3,
		ST_SX,
		ST_DIFF,
		ST_LHS,
		ST_CMP,
		ST_LOOP,
		ST_DECIDE
	} state_t;

	typedef enum logic [1:0] {
		SGN_NEG,
		SGN_ZERO,
		SGN_POS
	} sign_t;

	typedef enum logic [1:0] {
		TGT_A,
		TGT_B,
		TGT_MID
	} tgt_t;

endpackage

@@ design/rlev_mul.sv @@
// Shared multiplier: wide operand times value-width operand, one 32x32 product a cycle.
// Depends on nothing; used by the top level for every product.
module rlev_mul #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [4*VALUE_WIDTH-1:0] a,
	input  logic [VALUE_WIDTH-1:0]   b,
	output logic                     done,
	output logic [4*VALUE_WIDTH-1:0] product
);
	localparam int PW = 4 * VALUE_WIDTH;
	localparam int AW = (3 * VALUE_WIDTH + 31) / 32;
	localparam int BW = (VALUE_WIDTH + 31) / 32;
	localparam int IW = $clog2(AW);
	localparam int JW = (BW > 1) ? $clog2(BW) : 1;
	localparam int SW = $clog2(AW + BW);

	logic [PW-1:0]      a_q;
	logic [BW*32-1:0]   b_q;
	logic [IW-1:0]      i_q;
	logic [JW-1:0]      j_q;
	logic               run_q;
	logic               last_w;
	logic [63:0]        pp_s1;
	logic [SW-1:0]      sh_s1;
	logic               vld_s1;
	logic               last_s1;
	logic [PW-1:0]      acc_q;
	logic               done_q;

	assign last_w = (i_q == IW'(AW - 1)) && (j_q == JW'(BW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			vld_s1  <= run_q;
			last_s1 <= run_q && last_w;
			done_q  <= vld_s1 && last_s1;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
				j_q   <= '0;
			end else if (run_q) begin
				// advance b word first, then a word
				if (j_q == JW'(BW - 1)) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
				if (last_w)
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= (BW*32)'(b);
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + (PW'(pp_s1) << {sh_s1, 5'b0});
		end
		pp_s1 <= 64'(a_q[i_q*32 +: 32]) * 64'(b_q[j_q*32 +: 32]);
		sh_s1 <= SW'(i_q) + SW'(j_q);
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

@@ design/rng_les_effective_viscosity.sv @@
// Top level of the RNG LES effective viscosity block: APB registers, sequencer, datapath.
// Depends on rlev_pkg and rlev_mul.
//
// Finds the effective viscosity X = L*cbrt(1 + max(0, S*X/L^3 - C)) by bisection on
// [L, M*max(S,L)], testing the sign exactly by comparing L^3 + max(0, S*X*2^F - C*L^3)
// with X^3. Raise start with an item while busy is low; busy stays high until the result
// is out. The result appears on result for exactly one cycle with done high; there is no
// backpressure, so capture it in that cycle. fell_back marks that no sign change was
// found and L was returned. All products go through one 32x32 multiplier, so one product
// takes AW*BW partial products (AW = ceil(3*VALUE_WIDTH/32), BW = ceil(VALUE_WIDTH/32)).
// Setup takes four products; each tested point takes three products plus the DIFF, LHS
// and CMP steps, and each midpoint adds a DECIDE and a LOOP step. The search tests both
// ends once and then one midpoint per halving, about log2((M*max(S,L)-L)/tol) halvings,
// at most VALUE_WIDTH.
// Write registers only while busy is low.
module rng_les_effective_viscosity #(
	parameter int VALUE_WIDTH   = rlev_pkg::VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS = rlev_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  rlev_pkg::in_item_t                in_item,
	output logic                              done,
	output rlev_pkg::out_item_t               result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rlev_pkg::ADDR_WIDTH-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import rlev_pkg::*;

	localparam int W  = VALUE_WIDTH;
	localparam int PW = 4 * VALUE_WIDTH;

	// configuration registers
	logic [31:0] tol_q;
	logic [15:0] mc_q;
	logic [23:0] um_q;
	reg_idx_t    reg_idx;
	logic        wr_en;

	// sequencer
	state_t state_q, state_d;
	tgt_t   tgt_q;
	logic   issued_q;
	logic   done_q;

	// datapath
	logic [W-1:0]    l_q, s_q, ra_q, rb_q, r_q;
	logic [3*W-1:0]  l3_q, x3_q;
	logic [2*W-1:0]  x2_q, sx_q;
	logic [PW-1:0]   cl3_q, diff_q, lhs_q;
	logic            pos_q;
	sign_t           sa_q, sb_q, sc_q;
	out_item_t       result_q;

	// shared multiplier
	logic            mul_start;
	logic [PW-1:0]   mul_a;
	logic [W-1:0]    mul_b;
	logic            mul_done;
	logic [PW-1:0]   mul_p;
	logic            mul_fin;

	// combinational helpers
	logic [W-1:0]    l_in, s_in, big_w, cur_x, width_w, mid_w;
	logic [W-1:0]    mult_eff;
	logic [31:0]     tol_eff;
	logic            more_w;
	logic [PW-1:0]   sxs_w;
	logic [PW:0]     sub_w;
	sign_t           cmp_sign;
	logic            opp_a, opp_b;

	//--------------------------------------------------------------------------
	// APB register port; pready is always high, so a write lands in the access cycle
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
			mc_q  <= MC_RESET;
			um_q  <= UM_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_TOL: tol_q <= pwdata;
				REG_MC:  mc_q  <= pwdata[15:0];
				REG_UM:  um_q  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TOL: prdata = tol_q;
			REG_MC:  prdata = 32'(mc_q);
			REG_UM:  prdata = 32'(um_q);
			default: prdata = '0;
		endcase
	end

	//--------------------------------------------------------------------------
	// Helpers: clamp zero tolerance and multiplier to one, bisection width and midpoint
	assign l_in     = in_item.laminar_viscosity[W-1:0];
	assign s_in     = in_item.subgrid_viscosity[W-1:0];
	assign big_w    = (s_q > l_q) ? s_q : l_q;
	assign tol_eff  = (tol_q == '0) ? 32'd1 : tol_q;
	assign mult_eff = (um_q == '0) ? W'(1) : W'(um_q);
	assign width_w  = rb_q - ra_q;
	assign mid_w    = ra_q + (width_w >> 1);
	assign more_w   = width_w > W'(tol_eff);

	always_comb begin
		unique case (tgt_q)
			TGT_A:   cur_x = ra_q;
			TGT_B:   cur_x = rb_q;
			default: cur_x = r_q;
		endcase
	end

	// ramp: S*X scaled by 2^F against C*L^3
	assign sxs_w = PW'(sx_q) << FRACTION_BITS;
	assign sub_w = {1'b0, sxs_w} - {1'b0, cl3_q};

	always_comb begin
		if (lhs_q > PW'(x3_q))
			cmp_sign = SGN_POS;
		else if (lhs_q == PW'(x3_q))
			cmp_sign = SGN_ZERO;
		else
			cmp_sign = SGN_NEG;
	end

	assign opp_a = (sa_q == SGN_POS && sc_q == SGN_NEG) || (sa_q == SGN_NEG && sc_q == SGN_POS);
	assign opp_b = (sb_q == SGN_POS && sc_q == SGN_NEG) || (sb_q == SGN_NEG && sc_q == SGN_POS);

	assign mul_fin = issued_q && mul_done;

	//--------------------------------------------------------------------------
	// Sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_L2;
			ST_L2:     if (mul_fin) state_d = ST_L3;
			ST_L3:     if (mul_fin) state_d = ST_CL3;
			ST_CL3:    if (mul_fin) state_d = ST_UB;
			ST_UB:     if (mul_fin) state_d = ST_X2;
			ST_X2:     if (mul_fin) state_d = ST_X3;
			ST_X3:     if (mul_fin) state_d = ST_SX;
			ST_SX:     if (mul_fin) state_d = ST_DIFF;
			ST_DIFF:   state_d = ST_LHS;
			ST_LHS:    state_d = ST_CMP;
			ST_CMP: begin
				unique case (tgt_q)
					TGT_A:   state_d = ST_X2;
					TGT_B:   state_d = ST_LOOP;
					default: state_d = ST_DECIDE;
				endcase
			end
			ST_LOOP:   state_d = more_w ? ST_X2 : ST_IDLE;
			ST_DECIDE: begin
				if (sc_q == SGN_ZERO)
					state_d = ST_IDLE;
				else if (opp_a || opp_b)
					state_d = ST_LOOP;
				else
					state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer: multiplier operands and start pulse
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_L2: begin
				mul_a = PW'(l_q);
				mul_b = l_q;
			end
			ST_L3: begin
				mul_a = PW'(x2_q);
				mul_b = l_q;
			end
			ST_CL3: begin
				mul_a = PW'(l3_q);
				mul_b = W'(mc_q);
			end
			ST_UB: begin
				mul_a = PW'(big_w);
				mul_b = mult_eff;
			end
			ST_X2: begin
				mul_a = PW'(cur_x);
				mul_b = cur_x;
			end
			ST_X3: begin
				mul_a = PW'(x2_q);
				mul_b = cur_x;
			end
			ST_SX: begin
				mul_a = PW'(s_q);
				mul_b = cur_x;
			end
			default: ;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_L2, ST_L3, ST_CL3, ST_UB, ST_X2, ST_X3, ST_SX: mul_start = !issued_q;
			default: mul_start = 1'b0;
		endcase
	end

	//--------------------------------------------------------------------------
	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tgt_q    <= TGT_A;
			issued_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// hold issued until the product returns
			if (mul_start)
				issued_q <= 1'b1;
			else if (mul_fin)
				issued_q <= 1'b0;
			done_q <= ((state_q == ST_LOOP) && !more_w) ||
				((state_q == ST_DECIDE) && !(sc_q != SGN_ZERO && (opp_a || opp_b)));
			if (state_q == ST_IDLE)
				tgt_q <= TGT_A;
			else if (state_q == ST_CMP && tgt_q == TGT_A)
				tgt_q <= TGT_B;
			else if (state_q == ST_LOOP && more_w)
				tgt_q <= TGT_MID;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				l_q  <= l_in;
				s_q  <= s_in;
				ra_q <= l_in;
			end
			ST_L2:  if (mul_fin) x2_q  <= mul_p[2*W-1:0];
			ST_L3:  if (mul_fin) l3_q  <= mul_p[3*W-1:0];
			ST_CL3: if (mul_fin) cl3_q <= mul_p;
			ST_UB: begin
				// saturate the upper bound to the value range
				if (mul_fin)
					rb_q <= (mul_p[PW-1:W] != '0) ? '1 : mul_p[W-1:0];
			end
			ST_X2:  if (mul_fin) x2_q <= mul_p[2*W-1:0];
			ST_X3:  if (mul_fin) x3_q <= mul_p[3*W-1:0];
			ST_SX:  if (mul_fin) sx_q <= mul_p[2*W-1:0];
			ST_DIFF: begin
				diff_q <= sub_w[PW-1:0];
				pos_q  <= !sub_w[PW];
			end
			ST_LHS: lhs_q <= PW'(l3_q) + (pos_q ? diff_q : '0);
			ST_CMP: begin
				unique case (tgt_q)
					TGT_A:   sa_q <= cmp_sign;
					TGT_B:   sb_q <= cmp_sign;
					default: sc_q <= cmp_sign;
				endcase
			end
			ST_LOOP: begin
				if (more_w)
					r_q <= mid_w;
				else
					result_q <= '{effective_viscosity: 64'(mid_w), fell_back: 1'b0};
			end
			ST_DECIDE: begin
				if (sc_q == SGN_ZERO) begin
					result_q <= '{effective_viscosity: 64'(r_q), fell_back: 1'b0};
				end else if (opp_a) begin
					rb_q <= r_q;
					sb_q <= sc_q;
				end else if (opp_b) begin
					ra_q <= r_q;
					sa_q <= sc_q;
				end else begin
					// no sign change on either side: fall back to laminar
					result_q <= '{effective_viscosity: 64'(l_q), fell_back: 1'b1};
				end
			end
			default: ;
		endcase
	end

	rlev_mul #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

@@ design/rlev_chk.sv @@
// Port-level checker for the RNG LES effective viscosity block, bound to the top level.
// Depends on rlev_pkg.
module rlev_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input rlev_pkg::out_item_t result,
	input logic                pready
);
	import rlev_pkg::*;

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item taken but busy not raised");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside end of item");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_fb_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(result.fell_back) && pready)
		else $error("result flag unknown or port not ready");

endmodule

bind rng_les_effective_viscosity rlev_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result),
	.pready (pready)
);

@@ verif/rlev_checker.sv @@
`timescale 1ns / 100ps
// Checker for the RNG LES effective viscosity block: mirrors the registers from the
// APB bus, predicts each result by exact bisection and compares. Depends on rlev_pkg.
module rlev_checker
	import rlev_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  in_item_t              in_item,
	input  logic                  done,
	input  out_item_t             result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]           pwdata,
	input  logic                  pready,
	output int                    fail_count,
	output int                    pending
);

	logic [31:0] tol_reg;
	logic [15:0] mc_reg;
	logic [23:0] um_reg;
	out_item_t   viscosity_q[$];

	assign pending = viscosity_q.size();

	// sign of L^3*g - X^3, exact in 256 bits
	function automatic int residual_sign(logic [63:0] l, logic [63:0] s, logic [63:0] x);
		logic [255:0] l3, x3, sx, cl3, lhs;
		l3 = {192'd0, l} * l * l;
		x3 = {192'd0, x} * x * x;
		sx = ({192'd0, s} * x) << 40;
		cl3 = l3 * mc_reg;
		lhs = (sx > cl3) ? l3 + (sx - cl3) : l3;
		if (lhs > x3)
			return 1;
		else if (lhs < x3)
			return -1;
		return 0;
	endfunction

	function automatic out_item_t solve_viscosity(in_item_t it);
		out_item_t    o;
		logic [63:0]  l, s, tol, big, ra, rb, r;
		logic [127:0] prod;
		int           sa, sb, sc;
		l = it.laminar_viscosity;
		s = it.subgrid_viscosity;
		tol = (tol_reg == 0) ? 64'd1 : {32'd0, tol_reg};
		big = (s > l) ? s : l;
		prod = {64'd0, big} * ((um_reg == 0) ? 24'd1 : um_reg);
		rb = (prod[127:64] != 0) ? '1 : prod[63:0];
		ra = l;
		while (rb - ra > tol) begin
			sa = residual_sign(l, s, ra);
			sb = residual_sign(l, s, rb);
			r = ra + (rb - ra) / 2;
			sc = residual_sign(l, s, r);
			if (sc == 0) begin
				o.effective_viscosity = r;
				o.fell_back = 1'b0;
				return o;
			end
			if (sa * sc < 0)
				rb = r;
			else if (sb * sc < 0)
				ra = r;
			else begin
				o.effective_viscosity = l;
				o.fell_back = 1'b1;
				return o;
			end
		end
		o.effective_viscosity = ra + (rb - ra) / 2;
		o.fell_back = 1'b0;
		return o;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t mismatch: %s", $time, what);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			tol_reg <= TOL_RESET;
			mc_reg  <= MC_RESET;
			um_reg  <= UM_RESET;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_TOL: tol_reg <= pwdata;
					REG_MC:  mc_reg  <= pwdata[15:0];
					REG_UM:  um_reg  <= pwdata[23:0];
					default: ;
				endcase
			end
			if (start && !busy)
				viscosity_q.push_back(solve_viscosity(in_item));
			if (done) begin
				if (viscosity_q.size() == 0)
					report_mismatch("result with nothing expected");
				else begin
					want = viscosity_q.pop_front();
					if (result.effective_viscosity !== want.effective_viscosity)
						report_mismatch($sformatf("effective_viscosity %h, want %h",
							result.effective_viscosity, want.effective_viscosity));
					if (result.fell_back !== want.fell_back)
						report_mismatch($sformatf("fell_back %b, want %b",
							result.fell_back, want.fell_back));
				end
			end
		end
	end

endmodule

@@ verif/tb_rng_les_effective_viscosity.sv @@
`timescale 1ns / 100ps
// Testbench top for the RNG LES effective viscosity block: clock, reset, register
// phases, directed and random items, verdict. Depends on rlev_pkg and rlev_checker.
module tb_rng_les_effective_viscosity;
	import rlev_pkg::*;

	localparam int STALL_LIMIT = 60000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	in_item_t              in_item = '0;
	logic                  done;
	out_item_t             result;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_WIDTH-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;
	int                    fail_count;
	int                    pending;
	int                    idle_cycles = 0;

	rng_les_effective_viscosity uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	rlev_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready), .fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// Watchdog: only a long stretch with no accepted item, result or register write
	// ends the run.
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Setup cycle then access cycle; the register takes the value on the access edge.
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_WIDTH'({idx, 2'b00});
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Drain all results first so registers only change while the block is idle.
	task automatic set_phase(logic [31:0] tol, logic [15:0] mc, logic [23:0] um);
		wait (pending == 0 && !busy);
		write_reg(REG_TOL, tol);
		write_reg(REG_MC, {16'd0, mc});
		write_reg(REG_UM, {8'd0, um});
	endtask

	// Hold the item on the inputs after a random gap until the block takes it.
	task automatic send_item(logic [63:0] l, logic [63:0] s);
		repeat ($urandom_range(0, 8)) @(negedge clk);
		@(negedge clk);
		in_item.laminar_viscosity = l;
		in_item.subgrid_viscosity = s;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start = 1'b0;
	endtask

	// Spread magnitudes: fully random words, values near unity in Q24.40, and
	// random mantissas at random scale.
	function automatic logic [63:0] rand_viscosity();
		logic [63:0] v;
		case ($urandom_range(0, 3))
			0: v = {$urandom, $urandom};
			1: v = (64'd1 << 40) + {32'd0, $urandom} - 64'h8000_0000;
			default: v = {32'd0, $urandom} << $urandom_range(0, 32);
		endcase
		return v;
	endfunction

	task automatic run_random(int count);
		logic [63:0] l;
		for (int i = 0; i < count; i++) begin
			l = rand_viscosity();
			if ($urandom_range(0, 15) == 0)
				l = 64'd0;
			else if (l == 0)
				l = 64'd1;
			send_item(l, ($urandom_range(0, 9) == 0) ? 64'd0 : rand_viscosity());
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed items at reset settings: field extremes, zero laminar, zero subgrid
		send_item(64'd1, 64'd0);
		send_item(64'd1, '1);
		send_item('1, '1);
		send_item('1, 64'd0);
		send_item(64'd0, 64'd0);
		send_item(64'd0, '1);
		send_item(64'd1 << 40, 64'd1 << 40);
		send_item(64'd1 << 40, 64'd100 << 40);
		send_item(64'd1 << 40, 64'd0);
		send_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_item(64'd3 << 38, 64'd7 << 45);

		// widest tolerance, zero threshold, unit multiplier
		set_phase(32'hFFFF_FFFF, 16'd0, 24'd1);
		send_item(64'd1 << 40, 64'd5 << 40);
		run_random(80);

		// zero tolerance and zero multiplier fall back to one
		set_phase(32'd0, 16'd7, 24'd0);
		send_item(64'd1 << 40, 64'd1 << 40);
		run_random(40);

		// tightest tolerance, largest threshold and multiplier: slow, keep it short
		set_phase(32'd1, 16'hFFFF, 24'hFF_FFFF);
		send_item('1, '1);
		run_random(12);

		// reset-like settings
		set_phase(32'd110, 16'd100, 24'd10000000);
		run_random(40);

		// random settings, mostly loose tolerance and small multiplier for speed
		for (int p = 0; p < 10; p++) begin
			set_phase($urandom_range(32'h0010_0000, 32'hFFFF_FFFF),
				16'($urandom_range(0, 65535)),
				($urandom_range(0, 3) == 0) ? 24'($urandom_range(1, 24'hFF_FFFF))
				                            : 24'($urandom_range(1, 1000)));
			run_random(100);
		end

		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ rng_les_effective_viscosity.f @@
design/rlev_pkg.sv
design/rlev_mul.sv
design/rng_les_effective_viscosity.sv
design/rlev_chk.sv
verif/rlev_checker.sv
verif/tb_rng_les_effective_viscosity.sv
